// ===== rtl/rrca_pkg.sv =====
// Package for the round-robin channel allocator: sizes, action codes and the
// structs passed between the controller, the cell chain and the cells.
// No dependencies.
`default_nettype none

package rrca_pkg;

	localparam int MAX_CHANNELS = 256;
	localparam int CNT_W        = 9;
	localparam int SLOT_W       = $clog2(MAX_CHANNELS);
	localparam int CELL_BITS    = 16;
	localparam int LIDX_W       = $clog2(CELL_BITS);
	localparam int NUM_CELLS    = MAX_CHANNELS / CELL_BITS;
	localparam int CELL_IDX_W   = SLOT_W - LIDX_W;
	localparam int STEP_W       = $clog2(CNT_W);

	localparam logic ACT_RESERVE = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [SLOT_W-1:0] slot_t;

	typedef struct packed {
		logic  valid;
		logic  pass_b;
		slot_t start;
	} tok_t;

	typedef struct packed {
		logic  inj;
		slot_t start;
		logic  rel;
		slot_t rel_slot;
		logic  clear;
		cnt_t  count;
	} chain_cmd_t;

	typedef struct packed {
		logic  hit;
		logic  miss;
		slot_t slot;
		logic  rel_busy;
	} cell_rep_t;

endpackage

`default_nettype wire

// ===== rtl/rrca_req_if.sv =====
// Request channel of the channel allocator: valid/ready plus the request item.
// Depends on rrca_pkg.
`default_nettype none

interface rrca_req_if import rrca_pkg::*;;
	logic valid;
	logic ready;
	logic action;
	cnt_t channel_number;

	modport source (output valid, action, channel_number, input ready);
	modport sink (input valid, action, channel_number, output ready);
endinterface

`default_nettype wire

// ===== rtl/rrca_rsp_if.sv =====
// Response channel of the channel allocator: valid/ready plus the result item.
// Depends on rrca_pkg.
`default_nettype none

interface rrca_rsp_if import rrca_pkg::*;;
	logic valid;
	logic ready;
	cnt_t granted_channel;
	logic ok;
	cnt_t free_channels;

	modport source (output valid, granted_channel, ok, free_channels, input ready);
	modport sink (input valid, granted_channel, ok, free_channels, output ready);
endinterface

`default_nettype wire

// ===== rtl/rrca_cfg_if.sv =====
// Configuration write channel of the channel allocator: valid/ready plus the
// channel count. Depends on rrca_pkg.
`default_nettype none

interface rrca_cfg_if import rrca_pkg::*;;
	logic valid;
	logic ready;
	cnt_t total_channels;

	modport source (output valid, total_channels, input ready);
	modport sink (input valid, total_channels, output ready);
endinterface

`default_nettype wire

// ===== rtl/rrca_cell.sv =====
// One cell of the allocator chain: holds the busy bits of sixteen channels,
// searches them when the scan token arrives and passes the token on.
// Depends on rrca_pkg.
`default_nettype none

module rrca_cell import rrca_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [CELL_IDX_W-1:0] cell_idx,
	input  chain_cmd_t            cmd,
	input  tok_t                  tok_in,
	output tok_t                  tok_out,
	output cell_rep_t             rep
);

	logic [CELL_BITS-1:0] busy_q;
	tok_t                 tok_q;
	logic [CELL_BITS-1:0] cand;
	logic [LIDX_W-1:0]    first_j;
	logic                 hit;
	logic                 at_end;
	logic                 rel_here;
	tok_t                 tok_nx;

	always_comb begin
		slot_t slot_v;
		cand = '0;
		for (int j = 0; j < CELL_BITS; j++) begin
			slot_v = {cell_idx, LIDX_W'(j)};
			if (tok_in.pass_b)
				cand[j] = !busy_q[j] && (slot_v < tok_in.start);
			else
				cand[j] = !busy_q[j] && (slot_v >= tok_in.start)
					&& (CNT_W'(slot_v) < cmd.count);
		end
	end

	always_comb begin
		first_j = '0;
		for (int j = CELL_BITS - 1; j >= 0; j--) begin
			if (cand[j])
				first_j = LIDX_W'(j);
		end
	end

	assign hit      = tok_in.valid && (|cand);
	assign at_end   = tok_in.pass_b && (cell_idx == tok_in.start[SLOT_W-1:LIDX_W]);
	assign rel_here = cmd.rel && (cmd.rel_slot[SLOT_W-1:LIDX_W] == cell_idx);

	always_comb begin
		tok_nx        = tok_in;
		tok_nx.valid  = tok_in.valid && !hit && !at_end;
		tok_nx.pass_b = tok_in.pass_b || (cell_idx == {CELL_IDX_W{1'b1}});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
			tok_q  <= '0;
		end else begin
			tok_q <= tok_nx;
			if (cmd.clear) begin
				busy_q <= '0;
			end else begin
				if (hit)
					busy_q[first_j] <= 1'b1;
				if (rel_here)
					busy_q[cmd.rel_slot[LIDX_W-1:0]] <= 1'b0;
			end
		end
	end

	assign tok_out      = tok_q;
	assign rep.hit      = hit;
	assign rep.miss     = tok_in.valid && !hit && at_end;
	assign rep.slot     = hit ? {cell_idx, first_j} : '0;
	assign rep.rel_busy = rel_here && busy_q[cmd.rel_slot[LIDX_W-1:0]];

endmodule

`default_nettype wire

// ===== rtl/rrca_chain.sv =====
// Ring of allocator cells: injects the scan token at the start cell, links
// each cell to the next and merges the cell reports. Depends on rrca_pkg,
// rrca_cell.
`default_nettype none

module rrca_chain import rrca_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  chain_cmd_t           cmd,
	output cell_rep_t            rep,
	output logic [NUM_CELLS-1:0] hit_vec
);

	tok_t      tok_in  [NUM_CELLS];
	tok_t      tok_out [NUM_CELLS];
	cell_rep_t cell_rep [NUM_CELLS];

	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
		localparam int PREV = (k + NUM_CELLS - 1) % NUM_CELLS;

		always_comb begin
			if (cmd.inj && (cmd.start[SLOT_W-1:LIDX_W] == CELL_IDX_W'(k))) begin
				tok_in[k].valid  = 1'b1;
				tok_in[k].pass_b = 1'b0;
				tok_in[k].start  = cmd.start;
			end else begin
				tok_in[k] = tok_out[PREV];
			end
		end

		rrca_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (CELL_IDX_W'(k)),
			.cmd      (cmd),
			.tok_in   (tok_in[k]),
			.tok_out  (tok_out[k]),
			.rep      (cell_rep[k])
		);

		assign hit_vec[k] = cell_rep[k].hit;
	end

	always_comb begin
		rep = '0;
		for (int k = 0; k < NUM_CELLS; k++)
			rep = rep | cell_rep[k];
	end

endmodule

`default_nettype wire

// ===== rtl/round_robin_channel_allocator_top.sv =====
// Round-robin channel allocator: hands out channels 1..total_channels next-fit
// from the slot after the last grant, and takes them back on release. The busy
// bits sit in a ring of 16 cells of 16 channels each; a reserve sends a scan
// token around the ring, one cell per cycle; a zero count gives a result with
// no scan, and remainder steps first find the start slot when the last grant
// lies beyond a reduced count. A release goes straight to its result. A new
// item is taken once the previous result sits in the output register. Writing
// a count that differs from the current one frees all channels at once; no
// clearing pass is needed after reset.
// Depends on rrca_pkg, the channel interfaces and rrca_chain.
`default_nettype none

module round_robin_channel_allocator_top import rrca_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	rrca_cfg_if.sink     cfg,
	rrca_req_if.sink     req,
	rrca_rsp_if.source   rsp
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MOD  = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_REL  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]           state_q;
	cnt_t                 total_q;
	cnt_t                 free_q;
	logic                 ptr_none_q;
	slot_t                ptr_q;
	cnt_t                 num_q;
	slot_t                start_q;
	logic                 first_q;
	cnt_t                 div_q;
	cnt_t                 rem_q;
	logic [STEP_W-1:0]    step_q;
	cnt_t                 res_gr_q;
	logic                 res_ok_q;
	logic                 out_vld_q;
	cnt_t                 out_gr_q;
	logic                 out_ok_q;
	cnt_t                 out_free_q;

	chain_cmd_t           cmd;
	cell_rep_t            rep;
	logic [NUM_CELLS-1:0] hit_vec;

	logic                 in_acc;
	logic                 cfg_acc;
	cnt_t                 cfg_n;
	cnt_t                 ptr_p1;
	cnt_t                 rem_sh;
	cnt_t                 rem_nx;
	cnt_t                 tot_m1;
	logic                 rel_ok;
	logic                 out_load;

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign in_acc    = req.valid && req.ready;
	assign cfg_acc   = cfg.valid && cfg.ready;
	assign cfg_n     = (cfg.total_channels > CNT_W'(MAX_CHANNELS)) ?
		CNT_W'(MAX_CHANNELS) : cfg.total_channels;

	assign ptr_p1 = CNT_W'(ptr_q) + CNT_W'(1);
	assign tot_m1 = total_q - CNT_W'(1);
	assign rem_sh = {rem_q[CNT_W-2:0], div_q[CNT_W-1]};
	assign rem_nx = (rem_sh >= total_q) ? (rem_sh - total_q) : rem_sh;
	assign rel_ok = (num_q != '0) && (num_q <= total_q);
	assign out_load = (state_q == ST_DONE) && (!out_vld_q || rsp.ready);

	always_comb begin
		cmd          = '0;
		cmd.count    = total_q;
		cmd.inj      = (state_q == ST_SCAN) && first_q;
		cmd.start    = start_q;
		cmd.rel      = (state_q == ST_REL) && rel_ok;
		cmd.rel_slot = SLOT_W'(num_q - CNT_W'(1));
		cmd.clear    = cfg_acc && (cfg_n != total_q);
	end

	rrca_chain u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.rep     (rep),
		.hit_vec (hit_vec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			total_q    <= '0;
			free_q     <= '0;
			ptr_none_q <= 1'b1;
			ptr_q      <= '0;
			start_q    <= '0;
			first_q    <= 1'b0;
			div_q      <= '0;
			rem_q      <= '0;
			step_q     <= '0;
			res_gr_q   <= '0;
			res_ok_q   <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (req.action == ACT_RELEASE) begin
							state_q <= ST_REL;
						end else if (total_q == '0) begin
							res_gr_q <= '0;
							res_ok_q <= 1'b0;
							state_q  <= ST_DONE;
						end else if (ptr_none_q) begin
							start_q <= '0;
							first_q <= 1'b1;
							state_q <= ST_SCAN;
						end else if (CNT_W'(ptr_q) < total_q) begin
							start_q <= (ptr_p1 == total_q) ? '0 : ptr_p1[SLOT_W-1:0];
							first_q <= 1'b1;
							state_q <= ST_SCAN;
						end else begin
							div_q   <= ptr_p1;
							rem_q   <= '0;
							step_q  <= '0;
							state_q <= ST_MOD;
						end
					end
				end
				ST_MOD: begin
					rem_q  <= rem_nx;
					div_q  <= {div_q[CNT_W-2:0], 1'b0};
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(CNT_W - 1)) begin
						start_q <= rem_nx[SLOT_W-1:0];
						first_q <= 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					first_q <= 1'b0;
					if (rep.hit) begin
						ptr_q      <= rep.slot;
						ptr_none_q <= 1'b0;
						if (free_q != '0)
							free_q <= free_q - CNT_W'(1);
						res_gr_q   <= CNT_W'(rep.slot) + CNT_W'(1);
						res_ok_q   <= 1'b1;
						state_q    <= ST_DONE;
					end else if (rep.miss) begin
						ptr_q      <= (start_q == '0) ? tot_m1[SLOT_W-1:0] :
							start_q - SLOT_W'(1);
						ptr_none_q <= 1'b0;
						res_gr_q   <= '0;
						res_ok_q   <= 1'b0;
						state_q    <= ST_DONE;
					end
				end
				ST_REL: begin
					if (rel_ok && rep.rel_busy && (free_q < total_q))
						free_q <= free_q + CNT_W'(1);
					res_gr_q <= '0;
					res_ok_q <= rel_ok;
					state_q  <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (out_load)
				out_vld_q <= 1'b1;
			else if (rsp.ready)
				out_vld_q <= 1'b0;

			if (cfg_acc && (cfg_n != total_q)) begin
				total_q <= cfg_n;
				free_q  <= cfg_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			num_q <= req.channel_number;
		if (out_load) begin
			out_gr_q   <= res_gr_q;
			out_ok_q   <= res_ok_q;
			out_free_q <= free_q;
		end
	end

	assign rsp.valid           = out_vld_q;
	assign rsp.granted_channel = out_gr_q;
	assign rsp.ok              = out_ok_q;
	assign rsp.free_channels   = out_free_q;

	a_free_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= total_q)
		else $error("free count above channel count");

	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("more than one cell granted");

	a_hit_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(rep.hit || rep.miss) |-> (state_q == ST_SCAN))
		else $error("scan report outside of scan");

	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.granted_channel != '0)) |-> rsp.ok)
		else $error("granted channel without ok");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for round_robin_channel_allocator_top: a directed table, then random phases
// of reserve/release items under changing channel counts, each result checked in order.
// Depends on rrca_pkg, the rrca_*_if interfaces and the allocator RTL.

module tb_top;
	import rrca_pkg::*;

	localparam int ITEM_TARGET   = 1450;
	localparam int IDLE_PCT      = 29;
	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 40;
	localparam int DIR_ROWS      = 31;

	typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		cnt_t granted;
		logic ok;
		cnt_t free_n;
	} alloc_result_t;

	typedef struct packed {
		row_kind_t     kind;
		logic          act;
		cnt_t          num;
		bit            typed;
		alloc_result_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	bit   steady;
	int   mismatches;
	int   idle_cycles;
	int   rand_items;

	bit          chan_busy [MAX_CHANNELS];
	bit          grant_seen;
	int unsigned last_slot;
	int unsigned pool_size;
	int unsigned free_left;

	alloc_result_t grants_due [$];

	rrca_cfg_if cfg_ch ();
	rrca_req_if req_ch ();
	rrca_rsp_if rsp_ch ();

	round_robin_channel_allocator_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	dir_row_t dir_tab [0:DIR_ROWS-1] = '{
		'{ROW_ITEM, ACT_RESERVE, 9'd0,   1'b1, '{9'd0, 1'b0, 9'd0}},
		'{ROW_ITEM, ACT_RELEASE, 9'd0,   1'b1, '{9'd0, 1'b0, 9'd0}},
		'{ROW_ITEM, ACT_RELEASE, 9'd256, 1'b1, '{9'd0, 1'b0, 9'd0}},
		'{ROW_CFG,  ACT_RESERVE, 9'd3,   1'b0, '{9'd0, 1'b0, 9'd0}},
		'{ROW_ITEM, ACT_RESERVE, 9'd0,   1'b1, '{9'd1, 1'b1, 9'd2}},
		'{ROW_ITEM, ACT_RESERVE, 9'd0,   1'b1, '{9'd2, 1'b1, 9'd1}},
		'{ROW_ITEM, ACT_RESERVE, 9'd511, 1'b1, '{9'd3, 1'b1, 9'd0}},
		'{ROW_ITEM, ACT_RESERVE, 9'd0,   1'b1, '{9'd0, 1'b0, 9'd0}},
		'{ROW_ITEM, ACT_RELEASE, 9'd2,   1'b1, '{9'd0, 1'b1, 9'd1}},
		'{ROW_ITEM, ACT_RELEASE, 9'd2,   1'b1, '{9'd0, 1'b1, 9'd1}},
		'{ROW_ITEM, ACT_RELEASE, 9'd4,   1'b1, '{9'd0, 1'b0, 9'd1}},
		'{ROW_ITEM, ACT_RESERVE, 9'd0,   1'b1, '{9'd2, 1'b1, 9'd0}},
		'{ROW_CFG,  ACT_RESERVE, 9'd3,   1'b0, '{9'd0, 1'b0, 9'd0}},
		'{ROW_ITEM, ACT_RESERVE, 9'd0,   1'b1, '{9'd0, 1'b0, 9'd0}},
		'{ROW_CFG,  ACT_RESERVE, 9'd511, 1'b0, '{9'd0, 1'b0, 9'd0}},
		'{ROW_ITEM, ACT_RESERVE, 9'd0,   1'b1, '{9'd3, 1'b1, 9'd255}},
		'{ROW_ITEM, ACT_RELEASE, 9'd256, 1'b1, '{9'd0, 1'b1, 9'd255}},
		'{ROW_ITEM, ACT_RELEASE, 9'd257, 1'b1, '{9'd0, 1'b0, 9'd255}},
		'{ROW_ITEM, ACT_RELEASE, 9'd511, 1'b1, '{9'd0, 1'b0, 9'd255}},
		'{ROW_ITEM, ACT_RELEASE, 9'd3,   1'b0, '{9'd0, 1'b0, 9'd0}},
		'{ROW_CFG,  ACT_RESERVE, 9'd2,   1'b0, '{9'd0, 1'b0, 9'd0}},
		'{ROW_ITEM, ACT_RESERVE, 9'd0,   1'b0, '{9'd0, 1'b0, 9'd0}},
		'{ROW_ITEM, ACT_RESERVE, 9'd0,   1'b0, '{9'd0, 1'b0, 9'd0}},
		'{ROW_ITEM, ACT_RELEASE, 9'd1,   1'b0, '{9'd0, 1'b0, 9'd0}},
		'{ROW_CFG,  ACT_RESERVE, 9'd0,   1'b0, '{9'd0, 1'b0, 9'd0}},
		'{ROW_ITEM, ACT_RESERVE, 9'd0,   1'b0, '{9'd0, 1'b0, 9'd0}},
		'{ROW_CFG,  ACT_RESERVE, 9'd256, 1'b0, '{9'd0, 1'b0, 9'd0}},
		'{ROW_ITEM, ACT_RELEASE, 9'd170, 1'b0, '{9'd0, 1'b0, 9'd0}},
		'{ROW_ITEM, ACT_RESERVE, 9'd0,   1'b0, '{9'd0, 1'b0, 9'd0}},
		'{ROW_CFG,  ACT_RESERVE, 9'd1,   1'b0, '{9'd0, 1'b0, 9'd0}},
		'{ROW_ITEM, ACT_RESERVE, 9'd85,  1'b0, '{9'd0, 1'b0, 9'd0}}
	};

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		mismatches++;
	endtask

	function automatic void apply_count(input cnt_t value);
		int unsigned n;
		n = value;
		if (n > MAX_CHANNELS)
			n = MAX_CHANNELS;
		if (n != pool_size) begin
			pool_size = n;
			free_left = n;
			foreach (chan_busy[j])
				chan_busy[j] = 1'b0;
		end
	endfunction

	function automatic void predict_request(input logic act, input cnt_t num,
			output alloc_result_t res);
		int unsigned slot;
		int unsigned n;
		res = '0;
		if (act == ACT_RESERVE) begin
			for (int unsigned i = 0; i < pool_size; i++) begin
				slot = grant_seen ? (last_slot + 1) % pool_size : 0;
				grant_seen = 1'b1;
				last_slot = slot;
				if (!chan_busy[slot]) begin
					chan_busy[slot] = 1'b1;
					if (free_left > 0)
						free_left--;
					res.granted = cnt_t'(slot + 1);
					res.ok = 1'b1;
					break;
				end
			end
		end else begin
			n = num;
			if (n > 0 && n <= pool_size) begin
				if (chan_busy[n-1]) begin
					chan_busy[n-1] = 1'b0;
					if (free_left < pool_size)
						free_left++;
				end
				res.ok = 1'b1;
			end
		end
		res.free_n = cnt_t'(free_left);
	endfunction

	task automatic drain_results();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (grants_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_count(input cnt_t value);
		drain_results();
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.total_channels = value;
		do @(posedge clk); while (!cfg_ch.ready);
		apply_count(value);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic send_request(input logic act, input cnt_t num, input bit typed,
			input alloc_result_t given);
		alloc_result_t pred;
		@(negedge clk);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.action = act;
		req_ch.channel_number = num;
		do @(posedge clk); while (!req_ch.ready);
		predict_request(act, num, pred);
		grants_due.insert(grants_due.size(), typed ? given : pred);
	endtask

	always @(negedge clk)
		rsp_ch.ready = steady || ($urandom_range(99) >= IDLE_PCT);

	always @(posedge clk) begin : check_results
		alloc_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (grants_due.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending: granted %0d ok %0b free %0d",
					rsp_ch.granted_channel, rsp_ch.ok, rsp_ch.free_channels));
			end else begin
				want = grants_due.pop_front();
				if (rsp_ch.granted_channel !== want.granted)
					report_mismatch($sformatf("granted_channel %0d, expected %0d",
						rsp_ch.granted_channel, want.granted));
				if (rsp_ch.ok !== want.ok)
					report_mismatch($sformatf("ok %0b, expected %0b", rsp_ch.ok, want.ok));
				if (rsp_ch.free_channels !== want.free_n)
					report_mismatch($sformatf("free_channels %0d, expected %0d",
						rsp_ch.free_channels, want.free_n));
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int unsigned   phase;
		int unsigned   phase_len;
		int unsigned   reserve_pct;
		int unsigned   r;
		int unsigned   limit;
		cnt_t          count;
		cnt_t          num;
		logic          act;
		bit            prev_large;
		alloc_result_t none_given;

		none_given = '0;
		arst_n = 1'b0;
		steady = 1'b0;
		mismatches = 0;
		idle_cycles = 0;
		rand_items = 0;
		grant_seen = 1'b0;
		last_slot = 0;
		pool_size = 0;
		free_left = 0;
		cfg_ch.valid = 1'b0;
		cfg_ch.total_channels = '0;
		req_ch.valid = 1'b0;
		req_ch.action = ACT_RESERVE;
		req_ch.channel_number = '0;
		rsp_ch.ready = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_CFG)
				write_count(dir_tab[i].num);
			else
				send_request(dir_tab[i].act, dir_tab[i].num, dir_tab[i].typed, dir_tab[i].want);
		end

		phase = 0;
		prev_large = 1'b0;
		while (rand_items < ITEM_TARGET) begin
			steady = (phase >= 5 && phase < 9);
			r = $urandom_range(99);
			if (prev_large && $urandom_range(1))
				count = cnt_t'($urandom_range(16, 1));
			else if (r < 8)
				count = '0;
			else if (r < 18)
				count = cnt_t'(MAX_CHANNELS);
			else if (r < 26)
				count = cnt_t'($urandom_range(511, MAX_CHANNELS + 1));
			else if (r < 34)
				count = cnt_t'($urandom_range(MAX_CHANNELS - 1, 128));
			else if (r < 40)
				count = cnt_t'(1);
			else
				count = cnt_t'($urandom_range(16, 2));
			write_count(count);
			limit = (count > MAX_CHANNELS) ? MAX_CHANNELS : count;
			prev_large = (limit >= 128);
			if (prev_large) begin
				phase_len = $urandom_range(300, 120);
				reserve_pct = 85;
			end else begin
				phase_len = $urandom_range(60, 20);
				reserve_pct = $urandom_range(80, 30);
			end

			for (int unsigned k = 0; k < phase_len; k++) begin
				if ($urandom_range(99) < reserve_pct) begin
					act = ACT_RESERVE;
					num = cnt_t'($urandom_range(511, 0));
				end else begin
					act = ACT_RELEASE;
					r = $urandom_range(99);
					if (r < 10)
						num = '0;
					else if (r < 25 || limit == 0)
						num = cnt_t'($urandom_range(511, 0));
					else
						num = cnt_t'($urandom_range(limit, 1));
				end
				send_request(act, num, 1'b0, none_given);
				rand_items++;
				// now and then, hold off until the pipeline is empty
				if ($urandom_range(199) == 0)
					drain_results();
			end
			phase++;
		end

		steady = 1'b0;
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/rrca_pkg.sv
rtl/rrca_req_if.sv
rtl/rrca_rsp_if.sv
rtl/rrca_cfg_if.sv
rtl/rrca_cell.sv
rtl/rrca_chain.sv
rtl/round_robin_channel_allocator_top.sv
sim/tb_top.sv
